>>> design/ten_bit_word_packer_with_trailer_macros.svh
// Assertion macros for the ten-bit word packer.
`ifndef TEN_BIT_WORD_PACKER_WITH_TRAILER_MACROS_SVH
`define TEN_BIT_WORD_PACKER_WITH_TRAILER_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define TBWP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packer check failed");

// Consequent checked in the same cycle as the antecedent.
`define TBWP_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packer check failed");

`endif

>>> design/tbwp_pkg.sv
package tbwp_pkg;

  localparam int unsigned SlotBits      = 10;
  localparam int unsigned WordBits      = 32;
  localparam int unsigned SlotsPerBlock = 16;

  localparam logic [SlotBits-1:0] PAD_WORD = 10'h2AA;

  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_TRAILER = 2'd1;
  localparam logic [1:0] ACT_FLUSH   = 2'd2;

  typedef logic [2:0] step_t;

  localparam step_t STEP_DISPATCH = 3'd0;
  localparam step_t STEP_TRAILER  = 3'd1;
  localparam step_t STEP_FLUSH    = 3'd6;

  typedef enum logic [1:0] {
    OP_DISPATCH,
    OP_PACK,
    OP_LOOP_MOD4,
    OP_LOOP_BLOCK
  } op_t;

  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3
  } src_t;

  typedef enum logic [1:0] {
    REM_CONST,
    REM_MOD4,
    REM_FLUSH
  } rem_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [1:0] rem_const;
    step_t      next;
  } ucode_t;

  typedef struct packed {
    logic       pack;
    logic       load;
    src_t       src;
    rem_t       rem_sel;
    logic [1:0] rem_const;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    case (addr)
      3'd0:    w = '{op: OP_DISPATCH,   src: SRC_DATA, rem_const: 2'd0, next: 3'd0};
      3'd1:    w = '{op: OP_LOOP_MOD4,  src: SRC_PAD,  rem_const: 2'd0, next: 3'd2};
      3'd2:    w = '{op: OP_PACK,       src: SRC_T0,   rem_const: 2'd3, next: 3'd3};
      3'd3:    w = '{op: OP_PACK,       src: SRC_T1,   rem_const: 2'd2, next: 3'd4};
      3'd4:    w = '{op: OP_PACK,       src: SRC_T2,   rem_const: 2'd1, next: 3'd5};
      3'd5:    w = '{op: OP_PACK,       src: SRC_T3,   rem_const: 2'd0, next: 3'd0};
      3'd6:    w = '{op: OP_LOOP_BLOCK, src: SRC_PAD,  rem_const: 2'd0, next: 3'd0};
      default: w = '{op: OP_DISPATCH,   src: SRC_DATA, rem_const: 2'd0, next: 3'd0};
    endcase
    return w;
  endfunction

endpackage

>>> design/tbwp_seq.sv
module tbwp_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      action,
  input  logic            advance,
  input  logic [4:0]      free_slots,
  output logic            in_stall,
  output tbwp_pkg::ctrl_t ctrl
);
  import tbwp_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t uword;
  logic   take;
  logic   mod4_open;
  logic   block_open;

  assign uword      = ucode_rom(step);
  assign take       = in_valid && advance;
  assign mod4_open  = free_slots[1:0] != 2'd0;
  assign block_open = free_slots != 5'(SlotsPerBlock);

  always_comb begin
    step_next = step;
    unique case (uword.op)
      OP_DISPATCH: begin
        if (take) begin
          case (action)
            ACT_TRAILER: step_next = STEP_TRAILER;
            ACT_FLUSH:   step_next = STEP_FLUSH;
            default:     step_next = uword.next;
          endcase
        end
      end
      OP_PACK: begin
        if (advance) step_next = uword.next;
      end
      OP_LOOP_MOD4: begin
        if (advance && !mod4_open) step_next = uword.next;
      end
      OP_LOOP_BLOCK: begin
        if (advance && !block_open) step_next = uword.next;
      end
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    ctrl.pack      = 1'b0;
    ctrl.load      = 1'b0;
    ctrl.src       = uword.src;
    ctrl.rem_sel   = REM_CONST;
    ctrl.rem_const = uword.rem_const;
    unique case (uword.op)
      OP_DISPATCH: begin
        in_stall  = !advance;
        ctrl.load = take && (action == ACT_TRAILER);
        ctrl.pack = take && (action == ACT_DATA);
        ctrl.src  = SRC_DATA;
      end
      OP_PACK: begin
        ctrl.pack = advance;
      end
      OP_LOOP_MOD4: begin
        ctrl.pack    = advance && mod4_open;
        ctrl.rem_sel = REM_MOD4;
      end
      OP_LOOP_BLOCK: begin
        ctrl.pack    = advance && block_open;
        ctrl.rem_sel = REM_FLUSH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_DISPATCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> design/tbwp_datapath.sv
module tbwp_datapath (
  input  logic            clk,
  input  logic            rst,
  input  tbwp_pkg::ctrl_t ctrl,
  input  logic [9:0]      data_word,
  input  logic [9:0]      trailer_word_count,
  input  logic [9:0]      trailer_pad,
  input  logic [9:0]      trailer_row,
  input  logic [9:0]      trailer_sector,
  input  logic            out_stall,
  output logic            advance,
  output logic [4:0]      free_slots,
  output logic            out_valid,
  output logic [31:0]     out_word,
  output logic            block_end,
  output logic            run_last
);
  import tbwp_pkg::*;

  logic [9:0]  t0;
  logic [9:0]  t1;
  logic [9:0]  t2;
  logic [9:0]  t3;
  logic [31:0] partial_word;
  logic [31:0] partial_word_next;
  logic [5:0]  bits_free;
  logic [5:0]  bits_free_next;
  logic [4:0]  free_slots_next;
  logic [9:0]  slot;
  logic [31:0] slot_ext;
  logic [31:0] merged;
  logic [5:0]  bf_left;
  logic        emit;
  logic [31:0] emit_word;
  logic        emit_end;
  logic [4:0]  free_m1;
  logic [3:0]  rem_slots;
  logic [7:0]  rem_bits;
  logic        emit_last;

  assign advance = !out_valid || !out_stall;

  always_comb begin
    unique case (ctrl.src)
      SRC_DATA: slot = data_word;
      SRC_PAD:  slot = PAD_WORD;
      SRC_T0:   slot = t0;
      SRC_T1:   slot = t1;
      SRC_T2:   slot = t2;
      SRC_T3:   slot = t3;
      default:  slot = PAD_WORD;
    endcase
  end

  assign slot_ext = 32'(slot);

  always_comb begin
    partial_word_next = partial_word;
    bits_free_next    = bits_free;
    free_slots_next   = free_slots;
    bf_left           = bits_free;
    merged            = partial_word;
    emit              = 1'b0;
    emit_word         = partial_word;
    emit_end          = 1'b0;
    if (ctrl.pack) begin
      free_slots_next = free_slots - 5'd1;
      if (bits_free < 6'(SlotBits)) begin
        // split: high part closes the current word
        emit              = 1'b1;
        emit_word         = partial_word | (slot_ext >> (6'(SlotBits) - bits_free));
        bf_left           = bits_free + 6'(WordBits - SlotBits);
        partial_word_next = slot_ext << bf_left;
        bits_free_next    = bf_left;
      end else begin
        bf_left           = bits_free - 6'(SlotBits);
        merged            = partial_word | (slot_ext << bf_left);
        partial_word_next = merged;
        bits_free_next    = bf_left;
        if (bf_left == 6'd0) begin
          emit              = 1'b1;
          emit_word         = merged;
          emit_end          = 1'b1;
          partial_word_next = '0;
          bits_free_next    = 6'(WordBits);
          free_slots_next   = 5'(SlotsPerBlock);
        end
      end
    end
  end

  assign free_m1 = free_slots - 5'd1;

  always_comb begin
    unique case (ctrl.rem_sel)
      REM_CONST: rem_slots = 4'(ctrl.rem_const);
      REM_MOD4:  rem_slots = {2'b01, free_m1[1:0]};
      REM_FLUSH: rem_slots = free_m1[3:0];
      default:   rem_slots = 4'd0;
    endcase
  end

  // last word when the slots still to come cannot fill the free bits
  assign rem_bits  = {1'b0, rem_slots, 3'b000} + {3'b000, rem_slots, 1'b0};
  assign emit_last = rem_bits < 8'(bits_free_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      bits_free    <= 6'(WordBits);
      free_slots   <= 5'(SlotsPerBlock);
      out_valid    <= 1'b0;
    end else begin
      if (ctrl.pack) begin
        partial_word <= partial_word_next;
        bits_free    <= bits_free_next;
        free_slots   <= free_slots_next;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      t0 <= trailer_word_count;
      t1 <= trailer_pad;
      t2 <= trailer_row;
      t3 <= trailer_sector;
    end
    if (advance && emit) begin
      out_word  <= emit_word;
      block_end <= emit_end;
      run_last  <= emit_last;
    end
  end

endmodule

>>> design/ten_bit_word_packer_with_trailer.sv
// A completed 32-bit word is registered and appears in the cycle after the slot that completes it.
// The packing datapath takes one 10-bit slot per cycle while the output register does not stall it.
// A trailer pads to a multiple of 4 free slots, then adds 4 words; a flush fills out the open block.
// The output register stalls the slot sequencer while a word waits to be taken.
// Reset (synchronous, active high) empties the block and the output register.
module ten_bit_word_packer_with_trailer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [9:0]  data_word,
  input  logic [9:0]  trailer_word_count,
  input  logic [9:0]  trailer_pad,
  input  logic [9:0]  trailer_row,
  input  logic [9:0]  trailer_sector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic        block_end,
  output logic        run_last
);
  import tbwp_pkg::*;

  ctrl_t      ctrl;
  logic       advance;
  logic [4:0] free_slots;

  tbwp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .action     (action),
    .advance    (advance),
    .free_slots (free_slots),
    .in_stall   (in_stall),
    .ctrl       (ctrl)
  );

  tbwp_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .data_word          (data_word),
    .trailer_word_count (trailer_word_count),
    .trailer_pad        (trailer_pad),
    .trailer_row        (trailer_row),
    .trailer_sector     (trailer_sector),
    .out_stall          (out_stall),
    .advance            (advance),
    .free_slots         (free_slots),
    .out_valid          (out_valid),
    .out_word           (out_word),
    .block_end          (block_end),
    .run_last           (run_last)
  );

endmodule

>>> design/tbwp_checker.sv
`include "ten_bit_word_packer_with_trailer_macros.svh"

module tbwp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_word,
  input logic        block_end,
  input logic        run_last
);
  import tbwp_pkg::*;

  logic long_take;

  assign long_take = in_valid && !in_stall && (action == ACT_TRAILER || action == ACT_FLUSH);

  `TBWP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word) && $stable(block_end) && $stable(run_last))
  `TBWP_ASSERT_SAME(a_stall_when_blocked, clk, rst, out_valid && out_stall, in_stall)
  `TBWP_ASSERT_NEXT(a_busy_after_long, clk, rst, long_take, in_stall)

endmodule

bind ten_bit_word_packer_with_trailer tbwp_checker u_tbwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word),
  .block_end (block_end),
  .run_last  (run_last)
);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbwp_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int PhaseItems = 72;
  localparam int HoldCycles = 80;
  localparam int DrainCycles = 24;

  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
    logic        last;
  } packed_word_t;

  typedef struct {
    logic [1:0] act;
    logic [9:0] data;
    logic [9:0] wc;
    logic [9:0] pd;
    logic [9:0] rw;
    logic [9:0] sc;
    int         n_lit;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_DATA;
  logic [9:0]  data_word = '0;
  logic [9:0]  trailer_word_count = '0;
  logic [9:0]  trailer_pad = '0;
  logic [9:0]  trailer_row = '0;
  logic [9:0]  trailer_sector = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_word;
  logic        block_end;
  logic        run_last;

  ten_bit_word_packer_with_trailer dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .data_word          (data_word),
    .trailer_word_count (trailer_word_count),
    .trailer_pad        (trailer_pad),
    .trailer_row        (trailer_row),
    .trailer_sector     (trailer_sector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word           (out_word),
    .block_end          (block_end),
    .run_last           (run_last)
  );

  stim_row_t dir_rows [15] = '{
    '{ACT_FLUSH,   10'h000, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_SPARE,   10'h2AA, 10'h155, 10'h3FF, 10'h000, 10'h155,  0},
    '{ACT_TRAILER, 10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h000,  1},
    '{ACT_FLUSH,   10'h000, 10'h000, 10'h000, 10'h000, 10'h000,  4},
    '{ACT_DATA,    10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_DATA,    10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_DATA,    10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_DATA,    10'h000, 10'h000, 10'h000, 10'h000, 10'h000,  1},
    '{ACT_DATA,    10'h155, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_TRAILER, 10'h000, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, -1},
    '{ACT_TRAILER, 10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000, -1},
    '{ACT_DATA,    10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000,  0},
    '{ACT_SPARE,   10'h000, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,  0},
    '{ACT_FLUSH,   10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, -1},
    '{ACT_FLUSH,   10'h000, 10'h000, 10'h000, 10'h000, 10'h000,  0}
  };

  packed_word_t dir_words [6] = '{
    '{32'hFFC00FFC, 1'b0, 1'b1},
    '{32'h00AAAAAA, 1'b0, 1'b0},
    '{32'hAAAAAAAA, 1'b0, 1'b0},
    '{32'hAAAAAAAA, 1'b0, 1'b0},
    '{32'hAAAAAAAA, 1'b1, 1'b1},
    '{32'hFFFFFFFC, 1'b0, 1'b1}
  };

  packed_word_t expected_words[$];
  packed_word_t run_q[$];
  logic [31:0]  acc_word = '0;
  int           free_bits = WordBits;
  int           free_slots = SlotsPerBlock;
  int           lit_pos = 0;
  int           errors = 0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;
  bit           hold_req = 1'b0;

  function automatic void pack_slot(logic [9:0] v);
    logic [63:0] wide;
    wide = {54'd0, v};
    free_slots = free_slots - 1;
    if (free_bits < SlotBits) begin
      acc_word = acc_word | 32'(wide >> (SlotBits - free_bits));
      run_q.push_back('{acc_word, 1'b0, 1'b0});
      acc_word = '0;
      free_bits = free_bits + WordBits;
    end
    free_bits = free_bits - SlotBits;
    acc_word = acc_word | 32'(wide << free_bits);
    if (free_bits == 0) begin
      run_q.push_back('{acc_word, 1'b1, 1'b0});
      acc_word = '0;
      free_bits = WordBits;
      free_slots = SlotsPerBlock;
    end
  endfunction

  function automatic void pack_action(stim_row_t r);
    int pads;
    run_q.delete();
    case (r.act)
      ACT_DATA: begin
        pack_slot(r.data);
      end
      ACT_TRAILER: begin
        pads = free_slots % 4;
        for (int i = 0; i < pads; i++) pack_slot(PAD_WORD);
        pack_slot(r.wc);
        pack_slot(r.pd);
        pack_slot(r.rw);
        pack_slot(r.sc);
      end
      ACT_FLUSH: begin
        if (free_slots != SlotsPerBlock) begin
          pads = free_slots;
          for (int i = 0; i < pads; i++) pack_slot(PAD_WORD);
        end
      end
      default: begin
      end
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
  endfunction

  task automatic drive_word(input stim_row_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.act;
    data_word <= r.data;
    trailer_word_count <= r.wc;
    trailer_pad <= r.pd;
    trailer_row <= r.rw;
    trailer_sector <= r.sc;
    do @(posedge clk); while (in_stall);
    pack_action(r);
    if (r.n_lit < 0) begin
      foreach (run_q[i]) expected_words.push_back(run_q[i]);
    end else begin
      repeat (r.n_lit) begin
        expected_words.push_back(dir_words[lit_pos]);
        lit_pos++;
      end
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    packed_word_t exp_w;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word %h", out_word);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word !== exp_w.word) begin
            $error("out_word expected %h got %h", exp_w.word, out_word);
            errors++;
          end
          if (block_end !== exp_w.blk_end) begin
            $error("block_end expected %0b got %0b", exp_w.blk_end, block_end);
            errors++;
          end
          if (run_last !== exp_w.last) begin
            $error("run_last expected %0b got %0b", exp_w.last, run_last);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t r;
    int pick;
    int count;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 3; p++) begin
      in_idle_pct = (p == 0) ? 16 : (p == 1) ? 54 : 0;
      out_idle_pct = (p == 0) ? 54 : (p == 1) ? 16 : 0;
      if (p == 0) begin
        foreach (dir_rows[i]) drive_word(dir_rows[i]);
      end
      // hold the receiver off so the packer fills up and stalls its input
      if (p == 2) hold_req = 1'b1;
      count = 0;
      while (count < PhaseItems) begin
        pick = $urandom_range(99);
        r.act = (pick < 70) ? ACT_DATA : (pick < 82) ? ACT_TRAILER :
                (pick < 92) ? ACT_FLUSH : ACT_SPARE;
        r.data = 10'($urandom_range(1023));
        if ($urandom_range(9) == 0) r.data = $urandom_range(1) ? 10'h3FF : 10'h000;
        r.wc = 10'($urandom_range(1023));
        r.pd = 10'($urandom_range(1023));
        r.rw = 10'($urandom_range(1023));
        r.sc = 10'($urandom_range(1023));
        r.n_lit = -1;
        drive_word(r);
        count++;
      end
    end
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
